/* design/ccm_pkg.sv */
// ----------------------------------------------------------------------------
// ccm_pkg - shared definitions for the camera to Rec.2020 color matrix
// Sample and coefficient widths, fixed XYZ to Rec.2020 constants, register
// indexes and the shift-and-saturate helper used by both matrix passes.
// ----------------------------------------------------------------------------
package ccm_pkg;

  // Sample and fixed-point formats
  localparam int SAMPLE_BITS = 16;   // unsigned Q2.14 input samples
  localparam int FRAC_BITS   = 14;
  localparam int COEF_BITS   = 18;   // signed Q3.14 coefficients and results
  localparam int NUM_CH      = 3;
  localparam int CFG_W       = NUM_CH * COEF_BITS;
  localparam int REC_BITS    = 16;   // fixed constants fit in 16 signed bits

  // Product and accumulator widths of the two passes
  localparam int PROD1_W = SAMPLE_BITS + 1 + COEF_BITS;
  localparam int ACC1_W  = PROD1_W + 2;
  localparam int PROD2_W = COEF_BITS + REC_BITS;
  localparam int ACC2_W  = PROD2_W + 2;
  localparam int ACC_W   = (ACC1_W > ACC2_W) ? ACC1_W : ACC2_W;
  localparam int QUO_W   = ACC_W - FRAC_BITS;

  localparam int ROUND_HALF = 2 ** (FRAC_BITS - 1);
  localparam int SAT_MAX    = 2 ** (COEF_BITS - 1) - 1;
  localparam int SAT_MIN    = -(2 ** (COEF_BITS - 1));

  // Register reset values: identity camera-to-XYZ matrix
  localparam logic [CFG_W-1:0] ROW_X_RST = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ROW_Y_RST = CFG_W'(1) << (FRAC_BITS + COEF_BITS);
  localparam logic [CFG_W-1:0] ROW_Z_RST = CFG_W'(1) << (FRAC_BITS + 2 * COEF_BITS);

  // Register indexes
  typedef enum logic [1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_idx_e;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [REC_BITS-1:0]  rec_coef_t;

  // XYZ to Rec.2020, signed Q3.14, row = output channel
  localparam rec_coef_t REC_COEF [NUM_CH][NUM_CH] = '{
    '{ 16'sd26989,  -16'sd6449,  -16'sd3866},
    '{-16'sd11184,  16'sd26994,    16'sd210},
    '{   16'sd486,  -16'sd1031,  16'sd20544}
  };

  // Floor-divide a rounded sum by 2^FRAC_BITS and clamp to Q3.14
  function automatic coef_t shift_sat(input logic signed [ACC_W-1:0] v);
    logic signed [QUO_W-1:0] q;
    coef_t                   r;
    q = v[ACC_W-1:FRAC_BITS];
    if (q > QUO_W'(SAT_MAX)) begin
      r = COEF_BITS'(SAT_MAX);
    end else if (q < QUO_W'(SAT_MIN)) begin
      r = COEF_BITS'(SAT_MIN);
    end else begin
      r = q[COEF_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* design/ccm_if.sv */
// ----------------------------------------------------------------------------
// ccm_if - pixel channels of the color matrix
// Camera pixel channel and Rec.2020 pixel channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccm_in_if import ccm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] cam_red;
  logic [SAMPLE_BITS-1:0] cam_green;
  logic [SAMPLE_BITS-1:0] cam_blue;

  modport source (output valid, output cam_red, output cam_green, output cam_blue,
                  input ready);
  modport sink   (input valid, input cam_red, input cam_green, input cam_blue,
                  output ready);
endinterface

interface ccm_out_if import ccm_pkg::*; ();
  logic         valid;
  logic         ready;
  coef_t        out_red;
  coef_t        out_green;
  coef_t        out_blue;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  output ready);
endinterface

/* design/camera_to_rec2020_color_matrix.sv */
// ----------------------------------------------------------------------------
// camera_to_rec2020_color_matrix - camera RGB to Rec.2020 color conversion
// Programmable 3x3 camera-to-XYZ matrix followed by the fixed XYZ-to-Rec.2020
// matrix, each pass rounded to nearest and saturated to signed Q3.14.
//
//   channel   dir  payload                              handshake
//   pix_in    in   cam_red/green/blue, unsigned Q2.14   valid/ready
//   pix_out   out  out_red/green/blue, signed Q3.14     valid/ready
//   cfg       in   cfg_idx_i, cfg_data_i (54 bits)      cfg_we_i, no wait
//
// One pixel per clock while pix_out does not stall; each result passes
// through every register stage below before it appears on pix_out.
// Six register stages: multiply, sum, saturate, for each of the two matrices.
// Each stage holds when full and its successor is blocked, so bubbles close
// up under output backpressure. Reset clears stage valid bits and loads the
// identity camera matrix.
// ----------------------------------------------------------------------------
module camera_to_rec2020_color_matrix import ccm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  ccm_in_if.sink           pix_in,
  ccm_out_if.source        pix_out
);

  localparam int NSTG = 6;

  // Configuration registers
  logic [CFG_W-1:0] cam_row_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_row_q[0] <= ROW_X_RST;
      cam_row_q[1] <= ROW_Y_RST;
      cam_row_q[2] <= ROW_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_X: cam_row_q[0] <= cfg_data_i;
        CFG_ROW_Y: cam_row_q[1] <= cfg_data_i;
        CFG_ROW_Z: cam_row_q[2] <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Stage control: a stage advances when empty or when its successor advances
  logic [NSTG-1:0] vld_q, vld_d, stage_en;

  always_comb begin
    stage_en[NSTG-1] = !vld_q[NSTG-1] || pix_out.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
    vld_d[0] = stage_en[0] ? pix_in.valid : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = stage_en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pix_in.ready = stage_en[0];

  // Stage 1: camera matrix products
  logic signed [SAMPLE_BITS:0]  samp [NUM_CH];
  logic signed [PROD1_W-1:0]    prod1_d [NUM_CH][NUM_CH];
  logic signed [PROD1_W-1:0]    prod1_q [NUM_CH][NUM_CH];

  assign samp[0] = $signed({1'b0, pix_in.cam_red});
  assign samp[1] = $signed({1'b0, pix_in.cam_green});
  assign samp[2] = $signed({1'b0, pix_in.cam_blue});

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod1_d[r][c] = samp[c] * $signed(cam_row_q[r][c*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      prod1_q <= prod1_d;
    end
  end

  // Stage 2: sum products and add the rounding half
  logic signed [ACC1_W-1:0] sum1_d [NUM_CH];
  logic signed [ACC1_W-1:0] sum1_q [NUM_CH];

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      sum1_d[r] = ACC1_W'(prod1_q[r][0]) + ACC1_W'(prod1_q[r][1])
                + ACC1_W'(prod1_q[r][2]) + ACC1_W'(ROUND_HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      sum1_q <= sum1_d;
    end
  end

  // Stage 3: scale and saturate to XYZ
  coef_t xyz_d [NUM_CH];
  coef_t xyz_q [NUM_CH];

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      xyz_d[r] = shift_sat(ACC_W'(sum1_q[r]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      xyz_q <= xyz_d;
    end
  end

  // Stage 4: Rec.2020 matrix products
  logic signed [PROD2_W-1:0] prod2_d [NUM_CH][NUM_CH];
  logic signed [PROD2_W-1:0] prod2_q [NUM_CH][NUM_CH];

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod2_d[r][c] = xyz_q[c] * REC_COEF[r][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      prod2_q <= prod2_d;
    end
  end

  // Stage 5: sum products and add the rounding half
  logic signed [ACC2_W-1:0] sum2_d [NUM_CH];
  logic signed [ACC2_W-1:0] sum2_q [NUM_CH];

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      sum2_d[r] = ACC2_W'(prod2_q[r][0]) + ACC2_W'(prod2_q[r][1])
                + ACC2_W'(prod2_q[r][2]) + ACC2_W'(ROUND_HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      sum2_q <= sum2_d;
    end
  end

  // Stage 6: scale, saturate and hold in the output register
  coef_t rgb_d [NUM_CH];
  coef_t rgb_q [NUM_CH];

  always_comb begin
    for (int r = 0; r < NUM_CH; r++) begin
      rgb_d[r] = shift_sat(ACC_W'(sum2_q[r]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      rgb_q <= rgb_d;
    end
  end

  assign pix_out.valid     = vld_q[NSTG-1];
  assign pix_out.out_red   = rgb_q[0];
  assign pix_out.out_green = rgb_q[1];
  assign pix_out.out_blue  = rgb_q[2];

endmodule

/* bench/camera_to_rec2020_color_matrix_test.sv */
// ----------------------------------------------------------------------------
// camera_to_rec2020_color_matrix_test - self-checking bench for the color matrix
// Drives camera pixels through valid/ready with random gaps, programs several
// camera-to-XYZ matrices (reset identity, rounding, saturating and random
// rows), predicts each Rec.2020 pixel in fixed point and compares it field by
// field with the block's output in order of arrival.
// ----------------------------------------------------------------------------
module camera_to_rec2020_color_matrix_test import ccm_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;    // long output stall to back up the pipe
  localparam int DRAIN_CYCLES = 12;     // pipe is six stages deep
  localparam int PHASE_ITEMS  = 60;
  localparam int NUM_PHASES   = 8;

  localparam logic [1:0]             CFG_UNUSED     = 2'd3;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX     = '1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE     = 16'h4000;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_HALF    = 16'h2000;
  localparam logic [COEF_BITS-1:0]   COEF_ZERO      = 18'h00000;
  localparam logic [COEF_BITS-1:0]   COEF_ONE       = 18'h04000;
  localparam logic [COEF_BITS-1:0]   COEF_LSB       = 18'h00001;
  localparam logic [COEF_BITS-1:0]   COEF_MINUS_LSB = 18'h3FFFF;
  localparam logic [COEF_BITS-1:0]   COEF_POS_MAX   = 18'h1FFFF;
  localparam logic [COEF_BITS-1:0]   COEF_NEG_MAX   = 18'h20000;

  // XYZ to Rec.2020 in Q3.14, row = output channel
  localparam int XYZ_TO_REC [3][3] = '{
    '{ 26989,  -6449, -3866},
    '{-11184,  26994,   210},
    '{   486,  -1031, 20544}
  };

  typedef struct packed {
    coef_t red;
    coef_t green;
    coef_t blue;
  } rec_pixel_t;

  // Predict Rec.2020 pixels and match them against the block's output
  class rec2020_scoreboard;
    logic [CFG_W-1:0] cam_rows [3];
    rec_pixel_t       rec_pixels_due [$];
    int               errors;

    function new();
      cam_rows[0] = ROW_X_RST;
      cam_rows[1] = ROW_Y_RST;
      cam_rows[2] = ROW_Z_RST;
      errors      = 0;
    endfunction

    function void set_row(logic [1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_ROW_X: cam_rows[0] = value;
        CFG_ROW_Y: cam_rows[1] = value;
        CFG_ROW_Z: cam_rows[2] = value;
        default: ;  // unmapped index: no register
      endcase
    endfunction

    // Round half up at 14 fraction bits, clamp to signed Q3.14
    function longint round_clamp(longint acc);
      longint q;
      q = (acc + ROUND_HALF) >>> FRAC_BITS;
      if (q > SAT_MAX) begin
        q = SAT_MAX;
      end else if (q < SAT_MIN) begin
        q = SAT_MIN;
      end
      return q;
    endfunction

    function rec_pixel_t to_rec2020(logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] g,
                                    logic [SAMPLE_BITS-1:0] b);
      longint     s [3];
      longint     xyz [3];
      longint     rec [3];
      longint     acc;
      coef_t      c;
      rec_pixel_t p;
      s[0] = r;
      s[1] = g;
      s[2] = b;
      // Camera to XYZ with the programmed rows
      for (int row = 0; row < 3; row++) begin
        acc = 0;
        for (int col = 0; col < 3; col++) begin
          c   = cam_rows[row][col*COEF_BITS +: COEF_BITS];
          acc = acc + longint'(c) * s[col];
        end
        xyz[row] = round_clamp(acc);
      end
      // XYZ to Rec.2020 with the fixed constants
      for (int row = 0; row < 3; row++) begin
        acc = 0;
        for (int col = 0; col < 3; col++) begin
          acc = acc + longint'(XYZ_TO_REC[row][col]) * xyz[col];
        end
        rec[row] = round_clamp(acc);
      end
      p.red   = coef_t'(rec[0]);
      p.green = coef_t'(rec[1]);
      p.blue  = coef_t'(rec[2]);
      return p;
    endfunction

    function void note_camera_pixel(logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] g,
                                    logic [SAMPLE_BITS-1:0] b);
      rec_pixels_due.push_back(to_rec2020(r, g, b));
    endfunction

    function void check_rec2020_pixel(rec_pixel_t got);
      rec_pixel_t want;
      if (rec_pixels_due.size() == 0) begin
        $error("unexpected pixel: out_red %0d out_green %0d out_blue %0d",
               got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = rec_pixels_due.pop_front();
      if (got.red !== want.red) begin
        $error("out_red: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("out_green: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  ccm_in_if  pix_in_if ();
  ccm_out_if pix_out_if ();

  rec2020_scoreboard sb;
  bit                quiet;         // no gaps on either side
  bit                hold_request;  // ask the receiver for one long stall
  int                cycles;

  camera_to_rec2020_color_matrix dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_in_if),
    .pix_out    (pix_out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (quiet) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_W-1:0] pack_row(logic [COEF_BITS-1:0] cr,
                                                logic [COEF_BITS-1:0] cg,
                                                logic [COEF_BITS-1:0] cb);
    return {cb, cg, cr};
  endfunction

  // Coefficient within +-2.0, the usual range of a camera matrix
  function automatic logic [COEF_BITS-1:0] typical_coef();
    int v;
    v = int'($urandom_range(0, 65536)) - 32768;
    return v[COEF_BITS-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] typical_row();
    return pack_row(typical_coef(), typical_coef(), typical_coef());
  endfunction

  function automatic logic [CFG_W-1:0] random_row();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[CFG_W-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return SAMPLE_BITS'($urandom_range(0, 65535));
    end else if (roll < 90) begin
      return SAMPLE_BITS'($urandom_range(0, 16384));
    end else if (roll < 95) begin
      return '0;
    end
    return SAMPLE_MAX;
  endfunction

  // Register write; caller lowers the enable with cfg_done
  task automatic cfg_write(logic [1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_row(idx, value);
  endtask

  task automatic cfg_done();
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_matrix(logic [CFG_W-1:0] row_x, logic [CFG_W-1:0] row_y,
                             logic [CFG_W-1:0] row_z);
    cfg_write(CFG_ROW_X, row_x);
    cfg_write(CFG_ROW_Y, row_y);
    cfg_write(CFG_ROW_Z, row_z);
    cfg_done();
  endtask

  // Offer one pixel, hold it until the transfer, then idle a while
  task automatic send_pixel(logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] g,
                            logic [SAMPLE_BITS-1:0] b);
    int gap;
    pix_in_if.valid     <= 1'b1;
    pix_in_if.cam_red   <= r;
    pix_in_if.cam_green <= g;
    pix_in_if.cam_blue  <= b;
    do @(posedge clk_i); while (!pix_in_if.ready);
    sb.note_camera_pixel(r, g, b);
    gap = pick_gap();
    if (gap > 0) begin
      pix_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every pending pixel has come out
  task automatic drain();
    pix_in_if.valid <= 1'b0;
    while (sb.rec_pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: check each transfer, then pick the next ready level
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pix_out_if.valid && pix_out_if.ready) begin
        sb.check_rec2020_pixel('{red:   pix_out_if.out_red,
                                 green: pix_out_if.out_green,
                                 blue:  pix_out_if.out_blue});
        stall_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        pix_out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_out_if.ready <= 1'b0;
      end else begin
        pix_out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin
    logic [CFG_W-1:0] row_x;
    logic [CFG_W-1:0] row_y;
    logic [CFG_W-1:0] row_z;
    sb           = new();
    quiet        = 1'b0;
    hold_request = 1'b0;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_ROW_X;
    cfg_data_i          <= '0;
    pix_in_if.valid     <= 1'b0;
    pix_in_if.cam_red   <= '0;
    pix_in_if.cam_green <= '0;
    pix_in_if.cam_blue  <= '0;
    pix_out_if.ready    <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset identity matrix: sample extremes
    send_pixel('0, '0, '0);
    send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_pixel(SAMPLE_MAX, '0, '0);
    send_pixel('0, SAMPLE_MAX, '0);
    send_pixel('0, '0, SAMPLE_MAX);
    send_pixel(SAMPLE_ONE, SAMPLE_ONE, SAMPLE_ONE);
    drain();

    // Exact halves: +half rounds up, -half lands on zero
    load_matrix(pack_row(COEF_LSB, COEF_ZERO, COEF_ZERO),
                pack_row(COEF_MINUS_LSB, COEF_ZERO, COEF_ZERO),
                pack_row(COEF_LSB, COEF_LSB, COEF_MINUS_LSB));
    send_pixel(SAMPLE_HALF, '0, '0);
    send_pixel(SAMPLE_HALF + 16'd1, '0, '0);
    send_pixel(SAMPLE_HALF - 16'd1, SAMPLE_HALF, SAMPLE_MAX);
    send_pixel(16'h6000, 16'h2000, 16'h2000);
    drain();

    // XYZ saturation positive, then negative
    load_matrix(pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX),
                pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX),
                pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX));
    send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_pixel(SAMPLE_ONE, '0, '0);
    send_pixel(16'h0001, 16'h0001, 16'h0001);
    drain();
    load_matrix(pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX),
                pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX),
                pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX));
    send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_pixel('0, '0, SAMPLE_ONE);
    drain();

    // Output saturation both ways from mixed extreme rows
    load_matrix(pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX),
                pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX),
                pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX));
    send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    drain();
    load_matrix(pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX),
                pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX),
                pack_row(COEF_ZERO, COEF_ZERO, COEF_ZERO));
    send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    drain();

    // Unmapped index leaves the matrix alone
    load_matrix(pack_row(COEF_ONE, COEF_ZERO, COEF_ZERO),
                pack_row(COEF_ZERO, COEF_ONE, COEF_ZERO),
                pack_row(COEF_ZERO, COEF_ZERO, COEF_ONE));
    cfg_write(CFG_UNUSED, random_row());
    cfg_done();
    send_pixel(SAMPLE_ONE, SAMPLE_HALF, SAMPLE_MAX);
    drain();

    // Random phases, each with its own matrix
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1, 7: begin
          row_x = random_row();
          row_y = random_row();
          row_z = random_row();
        end
        2: begin
          row_x = pack_row(COEF_POS_MAX, COEF_NEG_MAX, COEF_POS_MAX);
          row_y = pack_row(COEF_NEG_MAX, COEF_POS_MAX, COEF_NEG_MAX);
          row_z = pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_NEG_MAX);
        end
        3: begin
          row_x = pack_row(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX);
          row_y = pack_row(COEF_MINUS_LSB, COEF_MINUS_LSB, COEF_MINUS_LSB);
          row_z = pack_row(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX);
        end
        4: begin
          row_x = '0;
          row_y = pack_row(COEF_LSB, COEF_MINUS_LSB, COEF_LSB);
          row_z = '1;
        end
        default: begin
          row_x = typical_row();
          row_y = typical_row();
          row_z = typical_row();
        end
      endcase
      load_matrix(row_x, row_y, row_z);
      if (phase == 7) begin
        cfg_write(CFG_UNUSED, random_row());
        cfg_done();
      end
      quiet = (phase == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back up the pipe while pixels keep coming
        if ((phase == 1 || phase == 5) && n == 10) begin
          hold_request = 1'b1;
        end
        send_pixel(random_sample(), random_sample(), random_sample());
      end
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0 && sb.rec_pixels_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
